/* sv/assert_macros.svh */
// assertion macros shared by the deframer rtl
// depends on nothing; taken in by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/slxd_pkg.sv */
// shared types and constants of the sync/length/xor deframer
// used by the front end, the record queue, the back end and the top level
package slxd_pkg;

    // sync pair
    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;

    // result status codes
    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_CSUM = 2'd2;

    // one frame record passed from front to back
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] frame_type;
        logic [6:0] length;
        logic       bank;
    } job_t;

    // payload buffer write from the front end
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [5:0] idx;
        logic [7:0] data;
    } wr_t;

    // buffer release from the back end
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

endpackage

/* sv/slxd_front.sv */
// front end: sync hunt, header parse, payload capture and checksum check
// depends on slxd_pkg; writes the payload buffers held in slxd_back
module slxd_front #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     rx_byte,
    input  logic           q_full,
    input  slxd_pkg::rel_t rel,
    output logic           push_valid,
    output slxd_pkg::job_t push_job,
    output slxd_pkg::wr_t  wr
);

    localparam logic [2:0] S_HUNT = 3'd0;
    localparam logic [2:0] S_SYNC = 3'd1;
    localparam logic [2:0] S_TYPE = 3'd2;
    localparam logic [2:0] S_LEN  = 3'd3;
    localparam logic [2:0] S_BODY = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [7:0] type_reg, type_next;
    logic [6:0] len_reg, len_next;
    logic [7:0] xor_reg, xor_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       bank_reg, bank_next;
    logic [1:0] busy_reg, busy_next;
    logic       accept;

    // stall while the record queue is full or the buffer to be filled is still draining
    assign in_ready = !q_full && !busy_reg[bank_reg];
    assign accept   = in_valid && in_ready;

    // frame parser
    always_comb
    begin
        state_next = state_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        cnt_next   = cnt_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        push_valid = 1'b0;
        push_job   = '0;
        wr         = '0;

        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            case (state_reg)
                S_HUNT:
                begin
                    if (rx_byte == slxd_pkg::SYNC_FIRST)
                    begin
                        state_next = S_SYNC;
                    end
                end
                S_SYNC:
                begin
                    if (rx_byte == slxd_pkg::SYNC_SECOND)
                    begin
                        state_next = S_TYPE;
                    end
                    else if (rx_byte != slxd_pkg::SYNC_FIRST)
                    begin
                        state_next = S_HUNT;
                    end
                end
                S_TYPE:
                begin
                    type_next  = rx_byte;
                    xor_next   = rx_byte;
                    state_next = S_LEN;
                end
                S_LEN:
                begin
                    if (rx_byte > 8'(MAX_PAYLOAD))
                    begin
                        push_valid        = 1'b1;
                        push_job.status   = slxd_pkg::ST_LEN;
                        type_next         = '0;
                        len_next          = '0;
                        xor_next          = '0;
                        state_next = (rx_byte == slxd_pkg::SYNC_FIRST) ? S_SYNC : S_HUNT;
                    end
                    else
                    begin
                        len_next   = rx_byte[6:0];
                        xor_next   = xor_reg ^ rx_byte;
                        cnt_next   = '0;
                        state_next = S_BODY;
                    end
                end
                S_BODY:
                begin
                    if (cnt_reg != len_reg)
                    begin
                        // payload byte
                        wr.en    = 1'b1;
                        wr.bank  = bank_reg;
                        wr.idx   = cnt_reg[5:0];
                        wr.data  = rx_byte;
                        xor_next = xor_reg ^ rx_byte;
                        cnt_next = cnt_reg + 7'd1;
                    end
                    else if (rx_byte != xor_reg)
                    begin
                        // checksum mismatch
                        push_valid      = 1'b1;
                        push_job.status = slxd_pkg::ST_CSUM;
                        type_next       = '0;
                        len_next        = '0;
                        xor_next        = '0;
                        cnt_next        = '0;
                        state_next = (rx_byte == slxd_pkg::SYNC_FIRST) ? S_SYNC : S_HUNT;
                    end
                    else
                    begin
                        // good frame, hand the buffer over
                        push_valid          = 1'b1;
                        push_job.status     = slxd_pkg::ST_GOOD;
                        push_job.frame_type = type_reg;
                        push_job.length     = len_reg;
                        push_job.bank       = bank_reg;
                        busy_next[bank_reg] = 1'b1;
                        bank_next           = !bank_reg;
                        type_next           = '0;
                        len_next            = '0;
                        xor_next            = '0;
                        cnt_next            = '0;
                        state_next          = S_HUNT;
                    end
                end
                default:
                begin
                    state_next = S_HUNT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
            type_reg  <= '0;
            len_reg   <= '0;
            xor_reg   <= '0;
            cnt_reg   <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
            cnt_reg   <= cnt_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

/* sv/slxd_fifo.sv */
// four-entry queue of frame records between front and back
// depends on slxd_pkg for the record type
module slxd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  slxd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output slxd_pkg::job_t head
);

    slxd_pkg::job_t ent_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full      = (cnt_reg == 3'd4);
    assign not_empty = (cnt_reg != 3'd0);
    assign head      = ent_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb
    begin
        wp_next  = do_push ? wp_reg + 2'd1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {2'd0, do_push} - {2'd0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wp_reg] <= push_job;
        end
    end

endmodule

/* sv/slxd_back.sv */
// back end: double payload buffer and result sequencer
// depends on slxd_pkg; takes records from slxd_fifo and buffer writes from slxd_front
module slxd_back #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  slxd_pkg::wr_t  wr,
    input  logic           q_valid,
    input  slxd_pkg::job_t q_job,
    output logic           q_pop,
    output slxd_pkg::rel_t rel,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     status,
    output logic [7:0]     frame_type,
    output logic [6:0]     body_length,
    output logic [5:0]     byte_index,
    output logic [7:0]     payload_byte,
    output logic           byte_valid,
    output logic           last
);

    localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int MEM_DEPTH = 2 << IDX_W;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;

    logic           active_reg, active_next;
    slxd_pkg::job_t job_reg, job_next;
    logic [5:0]     idx_reg, idx_next;
    logic [6:0]     len_m1;
    logic           fire, finish, load;
    logic [IDX_W:0] rd_addr;

    // result fields
    assign len_m1         = job_reg.length - 7'd1;
    assign out_valid      = active_reg;
    assign status         = job_reg.status;
    assign frame_type     = job_reg.frame_type;
    assign body_length    = job_reg.length;
    assign byte_index     = idx_reg;
    assign byte_valid     = (job_reg.status == slxd_pkg::ST_GOOD) && (job_reg.length != 7'd0);
    assign payload_byte   = byte_valid ? rd_data_reg : 8'd0;
    assign last           = !byte_valid || (idx_reg == len_m1[5:0]);

    // sequencing
    assign fire   = active_reg && out_ready;
    assign finish = fire && last;
    assign load   = (!active_reg || finish) && q_valid;
    assign q_pop  = load;

    assign rel.en   = finish && (job_reg.status == slxd_pkg::ST_GOOD);
    assign rel.bank = job_reg.bank;

    always_comb
    begin
        active_next = active_reg;
        job_next    = job_reg;
        idx_next    = idx_reg;
        if (load)
        begin
            active_next = 1'b1;
            job_next    = q_job;
            idx_next    = '0;
        end
        else if (finish)
        begin
            active_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 6'd1;
        end
    end

    // read ahead the byte that will be shown next cycle
    assign rd_addr = {job_next.bank, idx_next[IDX_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            job_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            job_reg    <= job_next;
            idx_reg    <= idx_next;
        end
    end

    // payload buffers, two banks
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[{wr.bank, wr.idx[IDX_W-1:0]}] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

/* sv/sync_length_xor_frame_deframer.sv */
// Frame deframer: hunts for the sync pair A5 5A, then takes type, length, payload and an
// XOR checksum byte. One received byte is accepted per cycle; results leave at one per
// cycle while out_ready is high. A good frame gives one result per payload byte (one
// result with byte_valid low for an empty payload), a rejected frame one error result.
// Input stalls only while four records wait in the record queue, or while both payload
// buffers hold good frames whose results are not yet all taken.
`include "assert_macros.svh"

module sync_length_xor_frame_deframer #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] frame_type,
    output logic [6:0] body_length,
    output logic [5:0] byte_index,
    output logic [7:0] payload_byte,
    output logic       byte_valid,
    output logic       last
);

    logic           push_valid;
    slxd_pkg::job_t push_job;
    slxd_pkg::wr_t  wr;
    slxd_pkg::rel_t rel;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    slxd_pkg::job_t q_job;

    // parser
    slxd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .q_full     (q_full),
        .rel        (rel),
        .push_valid (push_valid),
        .push_job   (push_job),
        .wr         (wr)
    );

    // record queue
    slxd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_job)
    );

    // result sequencer
    slxd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (wr),
        .q_valid        (q_valid),
        .q_job          (q_job),
        .q_pop          (q_pop),
        .rel            (rel),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .frame_type     (frame_type),
        .body_length    (body_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .last           (last)
    );

    // checks
    `ASSERT_SAME(a_err_single, clk, rst_n, out_valid && (status != slxd_pkg::ST_GOOD), last && !byte_valid)
    `ASSERT_SAME(a_run_good, clk, rst_n, out_valid && !last, (status == slxd_pkg::ST_GOOD) && byte_valid)
    `ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && out_ready && !last, out_valid && (byte_index == 6'($past(byte_index) + 6'd1)))
    `ASSERT_SAME(a_no_push_full, clk, rst_n, push_valid, !q_full)

endmodule

/* sim/testbench.sv */
// self-checking testbench for the sync/length/xor frame deframer
// depends on slxd_pkg and sync_length_xor_frame_deframer; a built-in predictor
// works out every expected result and a monitor checks what the block sends back
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_LIMIT = 32;
    localparam int STIM_BYTES    = 410;

    // hunt positions of the predictor
    localparam logic [6:0] POS_HUNT    = 7'd0;
    localparam logic [6:0] POS_SYNC1   = 7'd1;
    localparam logic [6:0] POS_TYPE    = 7'd2;
    localparam logic [6:0] POS_LEN     = 7'd3;
    localparam logic [6:0] POS_PAYLOAD = 7'd4;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] frame_type;
        logic [6:0] body_length;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } frame_result_t;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] frame_type;
    logic [6:0] body_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;

    // stimulus and expectation stores
    logic [7:0]    pending_bytes[$];
    frame_result_t expected_results[$];
    frame_result_t oldest_result;
    int            items_total    = 0;
    int            items_accepted = 0;
    int            fail_count     = 0;

    // sender and receiver pacing
    int            burst_left = 0;
    int            gap_left   = 0;
    rx_mode_t      ready_mode = RX_FREE;
    int            ready_left = 0;
    logic [1:0]    stall_tick = 2'd0;

    // predictor state
    logic [6:0]    pred_pos      = POS_HUNT;
    logic [7:0]    pred_type     = 8'd0;
    logic [6:0]    pred_len      = 7'd0;
    logic [7:0]    pred_xor      = 8'd0;
    logic [7:0]    pred_store[PAYLOAD_LIMIT];

    sync_length_xor_frame_deframer #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .frame_type    (frame_type),
        .body_length   (body_length),
        .byte_index    (byte_index),
        .payload_byte  (payload_byte),
        .byte_valid    (byte_valid),
        .last          (last)
    );

    always #4 clk = ~clk;

    // back to hunting with the held header cleared
    function automatic void clear_frame_state();
        pred_pos  = POS_HUNT;
        pred_type = 8'd0;
        pred_len  = 7'd0;
        pred_xor  = 8'd0;
    endfunction

    // one error result; an a5 on the failing byte starts a new header
    function automatic void reject_frame(input logic [1:0] code, input logic [7:0] b);
        frame_result_t r;
        r = '0;
        clear_frame_state();
        if (b == slxd_pkg::SYNC_FIRST)
            pred_pos = POS_SYNC1;
        r.status = code;
        r.last   = 1'b1;
        expected_results.push_back(r);
    endfunction

    // advance the deframer prediction by one received byte
    function automatic void deframe_predict(input logic [7:0] b);
        frame_result_t r;
        int            i;
        r = '0;
        case (pred_pos)
            POS_HUNT:
            begin
                if (b == slxd_pkg::SYNC_FIRST)
                    pred_pos = POS_SYNC1;
            end
            POS_SYNC1:
            begin
                if (b == slxd_pkg::SYNC_SECOND)
                    pred_pos = POS_TYPE;
                else if (b != slxd_pkg::SYNC_FIRST)
                    clear_frame_state();
            end
            POS_TYPE:
            begin
                pred_type = b;
                pred_xor  = b;
                pred_pos  = POS_LEN;
            end
            POS_LEN:
            begin
                if (b > PAYLOAD_LIMIT)
                    reject_frame(slxd_pkg::ST_LEN, b);
                else
                begin
                    pred_len = b[6:0];
                    pred_xor = pred_xor ^ b;
                    pred_pos = POS_PAYLOAD;
                end
            end
            default:
            begin
                if (pred_pos < POS_PAYLOAD + pred_len)
                begin
                    pred_store[5'(pred_pos - POS_PAYLOAD)] = b;
                    pred_xor = pred_xor ^ b;
                    pred_pos = pred_pos + 7'd1;
                end
                else if (b != pred_xor)
                    reject_frame(slxd_pkg::ST_CSUM, b);
                else
                begin
                    // good frame: one result per payload byte, or one for an empty one
                    r.status     = slxd_pkg::ST_GOOD;
                    r.frame_type = pred_type;
                    if (pred_len == 7'd0)
                    begin
                        r.last = 1'b1;
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        for (i = 0; i < pred_len; i++)
                        begin
                            r.body_length    = pred_len;
                            r.byte_index     = i[5:0];
                            r.payload_byte   = pred_store[i];
                            r.byte_valid     = 1'b1;
                            r.last           = (i + 1 == pred_len);
                            expected_results.push_back(r);
                        end
                    end
                    clear_frame_state();
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
    endfunction

    // whole frame; a length over the limit leaves only the header
    function automatic void add_frame(input logic [7:0] ftype, input logic [7:0] len,
                                      input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] d;
        int         i;
        push_byte(slxd_pkg::SYNC_FIRST);
        push_byte(slxd_pkg::SYNC_SECOND);
        push_byte(ftype);
        push_byte(len);
        sum = ftype ^ len;
        if (len > PAYLOAD_LIMIT)
            return;
        for (i = 0; i < len; i++)
        begin
            d = 8'($urandom_range(0, 255));
            push_byte(d);
            sum = sum ^ d;
        end
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        push_byte(sum);
    endfunction

    // sender: bursts of requests with random gaps, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                deframe_predict(rx_byte);
                items_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    rx_byte  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: free, random or sparse ready in stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode = rx_mode_t'($urandom_range(0, 2));
                ready_left = $urandom_range(8, 60);
            end
            else
                ready_left--;
            stall_tick = stall_tick + 2'd1;
            case (ready_mode)
                RX_FREE:   out_ready <= 1'b1;
                RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
                default:   out_ready <= (stall_tick == 2'd0);
            endcase
        end
    end

    // monitor: each result request against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no expectation waiting: status %0d", status);
                fail_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                check_field("status", oldest_result.status, status);
                check_field("frame_type", oldest_result.frame_type, frame_type);
                check_field("body_length", oldest_result.body_length, body_length);
                check_field("byte_index", oldest_result.byte_index, byte_index);
                check_field("payload_byte", oldest_result.payload_byte, payload_byte);
                check_field("byte_valid", oldest_result.byte_valid, byte_valid);
                check_field("last", oldest_result.last, last);
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int r;
        int n;
        int k;
        logic [7:0] len;

        foreach (pred_store[i])
            pred_store[i] = 8'd0;

        // noise at both extremes
        push_byte(8'h00);
        push_byte(8'hFF);
        // repeated sync, then an empty frame
        push_byte(slxd_pkg::SYNC_FIRST);
        add_frame(8'hFF, 8'd0, 1'b0);
        // broken sync
        push_byte(slxd_pkg::SYNC_FIRST);
        push_byte(8'h00);
        // length byte a5 is too large and restarts the header
        push_byte(slxd_pkg::SYNC_FIRST);
        push_byte(slxd_pkg::SYNC_SECOND);
        push_byte(8'h00);
        push_byte(slxd_pkg::SYNC_FIRST);
        push_byte(slxd_pkg::SYNC_SECOND);
        push_byte(8'h12);
        push_byte(8'h01);
        push_byte(8'h33);
        push_byte(8'h20);
        // length just over the limit
        add_frame(8'h01, 8'd33, 1'b0);
        // checksum mismatch on an a5, which restarts the header
        push_byte(slxd_pkg::SYNC_FIRST);
        push_byte(slxd_pkg::SYNC_SECOND);
        push_byte(8'h07);
        push_byte(8'h02);
        push_byte(8'h11);
        push_byte(8'h22);
        push_byte(slxd_pkg::SYNC_FIRST);
        push_byte(slxd_pkg::SYNC_SECOND);
        push_byte(8'h03);
        push_byte(8'h00);
        push_byte(8'h03);
        // good frame ending in a5 goes back to hunting
        add_frame(slxd_pkg::SYNC_FIRST, 8'd0, 1'b0);
        push_byte(slxd_pkg::SYNC_SECOND);

        // random part, one full-size frame first
        add_frame(8'($urandom_range(0, 255)), 8'd32, 1'b0);
        while (pending_bytes.size() < STIM_BYTES)
        begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 32))
                                               : 8'($urandom_range(0, 6));
            if (r < 70)
                add_frame(8'($urandom_range(0, 255)), len, 1'b0);
            else if (r < 80)
                add_frame(8'($urandom_range(0, 255)), len, 1'b1);
            else if (r < 88)
                add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(33, 255)), 1'b0);
            else if (r < 93)
            begin
                push_byte(slxd_pkg::SYNC_FIRST);
                push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    push_byte(8'($urandom_range(0, 255)));
            end
        end
        items_total = pending_bytes.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_accepted != items_total)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
